### sv/rhh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rhh_pkg;

   localparam int HASH_W    = 32;
   localparam int TAG_W     = 32;
   localparam int ENTRY_W   = HASH_W + TAG_W;
   localparam int KEY_IN_W  = 256;
   localparam int DIV_BITS  = 4;
   localparam int SLOT_W    = 10;
   localparam int LP_OUT_W  = 11;
   localparam int TS_W      = 11;
   localparam int KB_W      = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 11;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_SIZE = 2'd0,
      CSR_KEY_BYTES  = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_FIND   = 2'd1,
      CMD_CLEAR  = 2'd2
   } command_type;

   typedef enum logic [2:0] {
      STS_INSERTED  = 3'd0,
      STS_FOUND     = 3'd1,
      STS_NOT_FOUND = 3'd2,
      STS_FULL      = 3'd3,
      STS_ZERO_HASH = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_HOME,
      S_SCAN_RD,
      S_SCAN_EV,
      S_INS_RD,
      S_INS_EV,
      S_INS_DIV,
      S_FIND_RD,
      S_FIND_EV,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] hash_value;
      logic [31:0] entry_tag;
      logic [63:0] key_word0;
      logic [63:0] key_word1;
      logic [63:0] key_word2;
      logic [63:0] key_word3;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [SLOT_W-1:0]   slot_index;
      logic [LP_OUT_W-1:0] longest_probe_out;
      logic                resize_wanted;
   } rsp_type;

   typedef struct packed {
      logic rd;
      logic wr_entry;
      logic wr_key;
   } mem_ctl_type;

endpackage

`default_nettype wire

### sv/rhh_mod.sv
`timescale 1ns / 1ps
`default_nettype none

// Remainder of a 32-bit hash by the table size, DIV_BITS bits per cycle.
module rhh_mod #(
   parameter int SZ_W = 11
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [rhh_pkg::HASH_W-1:0]    dividend,
   input  wire logic [SZ_W-1:0]               divisor,
   output logic                               done,
   output logic [SZ_W-1:0]                    remainder
);

   localparam int RW    = SZ_W + 1;
   localparam int STEPS = rhh_pkg::HASH_W / rhh_pkg::DIV_BITS;
   localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [rhh_pkg::HASH_W-1:0]   dvd_ff, dvd_in;
   logic [RW-1:0]                rem_ff, rem_in;
   logic [SZ_W-1:0]              dvs_ff, dvs_in;
   logic [RW-1:0]                r;
   logic [rhh_pkg::HASH_W-1:0]   d;

   // Shift in DIV_BITS dividend bits, subtract where the partial remainder allows
   always_comb begin
      r = rem_ff;
      d = dvd_ff;
      for (int k = 0; k < rhh_pkg::DIV_BITS; k++) begin
         r = {r[RW-2:0], d[rhh_pkg::HASH_W-1]};
         d = {d[rhh_pkg::HASH_W-2:0], 1'b0};
         if (r >= {1'b0, dvs_ff}) begin
            r = r - {1'b0, dvs_ff};
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in = d;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[SZ_W-1:0];

endmodule

`default_nettype wire

### sv/rhh_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Slot memories: {tag, hash} per slot and the stored key, one port each.
module rhh_store #(
   parameter int CAPACITY = 1024,
   parameter int KW       = 256
) (
   input  wire logic                            clock,
   input  wire rhh_pkg::mem_ctl_type            ctl,
   input  wire logic [$clog2(CAPACITY)-1:0]     addr,
   input  wire logic [rhh_pkg::ENTRY_W-1:0]     wr_entry,
   input  wire logic [KW-1:0]                   wr_key,
   output logic [rhh_pkg::ENTRY_W-1:0]          rd_entry,
   output logic [KW-1:0]                        rd_key
);

   logic [rhh_pkg::ENTRY_W-1:0] entry_mem [CAPACITY];
   logic [KW-1:0]               key_mem   [CAPACITY];
   logic [rhh_pkg::ENTRY_W-1:0] rd_entry_ff;
   logic [KW-1:0]               rd_key_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_entry) begin
         entry_mem[addr] <= wr_entry;
      end
      if (ctl.rd) begin
         rd_entry_ff <= entry_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_key) begin
         key_mem[addr] <= wr_key;
      end
      if (ctl.rd) begin
         rd_key_ff <= key_mem[addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_key   = rd_key_ff;

endmodule

`default_nettype wire

### sv/rhh_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Command sequencer: home lookup, empty scan, Robin Hood walk, find, clear.
module rhh_ctrl #(
   parameter int CAPACITY      = 1024,
   parameter int MAX_KEY_BYTES = 32,
   parameter int PROBE_FLOOR   = 24
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire rhh_pkg::req_type                       req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output rhh_pkg::rsp_type                            rsp_data,
   input  wire logic [rhh_pkg::TS_W-1:0]               table_size,
   input  wire logic [rhh_pkg::KB_W-1:0]               key_bytes,
   output rhh_pkg::mem_ctl_type                        mem_ctl,
   output logic [$clog2(CAPACITY)-1:0]                 mem_addr,
   output logic [rhh_pkg::ENTRY_W-1:0]                 mem_wr_entry,
   output logic [MAX_KEY_BYTES*8-1:0]                  mem_wr_key,
   input  wire logic [rhh_pkg::ENTRY_W-1:0]            mem_rd_entry,
   input  wire logic [MAX_KEY_BYTES*8-1:0]             mem_rd_key,
   output logic                                        div_start,
   output logic [rhh_pkg::HASH_W-1:0]                  div_dividend,
   output logic [$clog2(CAPACITY+1)-1:0]               div_divisor,
   input  wire logic                                   div_done,
   input  wire logic [$clog2(CAPACITY+1)-1:0]          div_rem
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int SZ_W  = $clog2(CAPACITY + 1);
   localparam int PW    = (SZ_W > 9) ? SZ_W : 9;
   localparam int KW    = MAX_KEY_BYTES * 8;
   localparam int KBE_W = $clog2(MAX_KEY_BYTES + 1);

   rhh_pkg::state_type          state_ff, state_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [IDX_W-1:0]            home_ff, home_in;
   logic [SZ_W-1:0]             step_ff, step_in;
   logic [PW-1:0]               probe_ff, probe_in;
   logic [PW-1:0]               lp_ff, lp_in;
   logic [1:0]                  cmd_ff, cmd_in;
   logic [rhh_pkg::HASH_W-1:0]  hash_ff, hash_in;
   logic [rhh_pkg::ENTRY_W-1:0] cur_ff, cur_in;
   logic [KW-1:0]               ck_ff, ck_in;
   logic [2:0]                  sts_ff, sts_in;
   logic [IDX_W-1:0]            slot_ff, slot_in;
   logic                        clr_rsp_ff, clr_rsp_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rhh_pkg::rsp_type            rsp_ff, rsp_in;

   logic [SZ_W-1:0]             size_eff;
   logic [KBE_W-1:0]            kb_eff;
   logic [KW-1:0]               kmask;
   logic [rhh_pkg::KEY_IN_W-1:0] key_all;
   logic [IDX_W-1:0]            idx_next;
   logic [SZ_W-1:0]             idx_e;
   logic [SZ_W-1:0]             res_dist;
   logic [PW-1:0]               last;
   logic [rhh_pkg::HASH_W-1:0]  res_hash;
   logic                        accept;

   // Clamp the configuration to the legal ranges
   always_comb begin
      if (table_size < rhh_pkg::TS_W'(2)) begin
         size_eff = SZ_W'(2);
      end else if (32'(table_size) > 32'(CAPACITY)) begin
         size_eff = SZ_W'(CAPACITY);
      end else begin
         size_eff = SZ_W'(table_size);
      end
      if (key_bytes == '0) begin
         kb_eff = KBE_W'(1);
      end else if (32'(key_bytes) > 32'(MAX_KEY_BYTES)) begin
         kb_eff = KBE_W'(MAX_KEY_BYTES);
      end else begin
         kb_eff = KBE_W'(key_bytes);
      end
   end

   // Byte mask of the compared key length
   always_comb begin
      for (int b = 0; b < MAX_KEY_BYTES; b++) begin
         kmask[b*8 +: 8] = (b < int'(kb_eff)) ? 8'hFF : 8'h00;
      end
   end

   assign key_all  = {req_data.key_word3, req_data.key_word2,
                      req_data.key_word1, req_data.key_word0};
   assign idx_e    = SZ_W'(idx_ff);
   assign idx_next = (idx_e + 1'b1 == size_eff) ? '0 : idx_ff + 1'b1;
   assign res_dist = (idx_e >= div_rem) ? idx_e - div_rem : idx_e + size_eff - div_rem;
   assign last     = (lp_ff < PW'(size_eff - 1'b1)) ? lp_ff : PW'(size_eff - 1'b1);
   assign res_hash = mem_rd_entry[rhh_pkg::HASH_W-1:0];
   assign accept   = req_valid && !req_stall;

   assign req_stall    = (state_ff != rhh_pkg::S_IDLE);
   assign div_divisor  = size_eff;
   assign div_dividend = (state_ff == rhh_pkg::S_IDLE) ? req_data.hash_value : res_hash;
   assign mem_addr     = idx_ff;
   assign mem_wr_entry = (state_ff == rhh_pkg::S_CLEAR) ? '0 : cur_ff;
   assign mem_wr_key   = ck_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      home_in      = home_ff;
      step_in      = step_ff;
      probe_in     = probe_ff;
      lp_in        = lp_ff;
      cmd_in       = cmd_ff;
      hash_in      = hash_ff;
      cur_in       = cur_ff;
      ck_in        = ck_ff;
      sts_in       = sts_ff;
      slot_in      = slot_ff;
      clr_rsp_in   = clr_rsp_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_ctl      = '0;
      div_start    = 1'b0;

      unique case (state_ff)
         // Sweep every slot to empty
         rhh_pkg::S_CLEAR: begin
            mem_ctl.wr_entry = 1'b1;
            if (idx_ff == IDX_W'(CAPACITY - 1)) begin
               idx_in   = '0;
               state_in = clr_rsp_ff ? rhh_pkg::S_DONE : rhh_pkg::S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         rhh_pkg::S_IDLE: begin
            if (accept) begin
               cmd_in     = req_data.command;
               hash_in    = req_data.hash_value;
               cur_in     = {req_data.entry_tag, req_data.hash_value};
               ck_in      = key_all[KW-1:0] & kmask;
               slot_in    = '0;
               clr_rsp_in = 1'b0;
               case (req_data.command) inside
                  rhh_pkg::CMD_INSERT, rhh_pkg::CMD_FIND: begin
                     if (req_data.hash_value == '0) begin
                        sts_in   = rhh_pkg::STS_ZERO_HASH;
                        state_in = rhh_pkg::S_DONE;
                     end else begin
                        div_start = 1'b1;
                        state_in  = rhh_pkg::S_HOME;
                     end
                  end
                  rhh_pkg::CMD_CLEAR: begin
                     idx_in     = '0;
                     clr_rsp_in = 1'b1;
                     sts_in     = rhh_pkg::STS_INSERTED;
                     state_in   = rhh_pkg::S_CLEAR;
                  end
                  default: begin
                     sts_in   = rhh_pkg::STS_NOT_FOUND;
                     state_in = rhh_pkg::S_DONE;
                  end
               endcase
            end
         end

         // Wait for the home slot of the request hash
         rhh_pkg::S_HOME: begin
            if (div_done) begin
               home_in  = IDX_W'(div_rem);
               idx_in   = IDX_W'(div_rem);
               step_in  = '0;
               probe_in = '0;
               state_in = (cmd_ff == rhh_pkg::CMD_INSERT) ? rhh_pkg::S_SCAN_RD
                                                          : rhh_pkg::S_FIND_RD;
            end
         end

         rhh_pkg::S_SCAN_RD: begin
            mem_ctl.rd = 1'b1;
            state_in   = rhh_pkg::S_SCAN_EV;
         end

         // Look for any empty slot before moving entries
         rhh_pkg::S_SCAN_EV: begin
            if (res_hash == '0) begin
               idx_in   = home_ff;
               state_in = rhh_pkg::S_INS_RD;
            end else if (step_ff + 1'b1 == size_eff) begin
               sts_in   = rhh_pkg::STS_FULL;
               state_in = rhh_pkg::S_DONE;
            end else begin
               step_in  = step_ff + 1'b1;
               idx_in   = idx_next;
               state_in = rhh_pkg::S_SCAN_RD;
            end
         end

         rhh_pkg::S_INS_RD: begin
            mem_ctl.rd = 1'b1;
            state_in   = rhh_pkg::S_INS_EV;
         end

         // Place into an empty slot, else get the resident's home
         rhh_pkg::S_INS_EV: begin
            if (res_hash == '0) begin
               mem_ctl.wr_entry = 1'b1;
               mem_ctl.wr_key   = 1'b1;
               if (probe_ff > lp_ff) begin
                  lp_in = probe_ff;
               end
               sts_in   = rhh_pkg::STS_INSERTED;
               state_in = rhh_pkg::S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = rhh_pkg::S_INS_DIV;
            end
         end

         // Swap with a resident closer to its home, then advance
         rhh_pkg::S_INS_DIV: begin
            if (div_done) begin
               if (PW'(res_dist) < probe_ff) begin
                  mem_ctl.wr_entry = 1'b1;
                  mem_ctl.wr_key   = 1'b1;
                  if (probe_ff > lp_ff) begin
                     lp_in = probe_ff;
                  end
                  cur_in   = mem_rd_entry;
                  ck_in    = mem_rd_key;
                  probe_in = PW'(res_dist) + 1'b1;
               end else begin
                  probe_in = probe_ff + 1'b1;
               end
               idx_in   = idx_next;
               state_in = rhh_pkg::S_INS_RD;
            end
         end

         rhh_pkg::S_FIND_RD: begin
            mem_ctl.rd = 1'b1;
            state_in   = rhh_pkg::S_FIND_EV;
         end

         // Compare hash and masked key, stop at the longest probe
         rhh_pkg::S_FIND_EV: begin
            if (res_hash == hash_ff && (mem_rd_key & kmask) == ck_ff) begin
               slot_in  = idx_ff;
               sts_in   = rhh_pkg::STS_FOUND;
               state_in = rhh_pkg::S_DONE;
            end else if (PW'(step_ff) == last) begin
               sts_in   = rhh_pkg::STS_NOT_FOUND;
               state_in = rhh_pkg::S_DONE;
            end else begin
               step_in  = step_ff + 1'b1;
               idx_in   = idx_next;
               state_in = rhh_pkg::S_FIND_RD;
            end
         end

         // Hand the word to the output register once it is free
         rhh_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.status            = sts_ff;
               rsp_in.slot_index        = rhh_pkg::SLOT_W'(slot_ff);
               rsp_in.longest_probe_out = rhh_pkg::LP_OUT_W'(lp_ff);
               rsp_in.resize_wanted     = (lp_ff > PW'(PROBE_FLOOR));
               rsp_valid_in             = 1'b1;
               state_in                 = rhh_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = rhh_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rhh_pkg::S_CLEAR;
         idx_ff       <= '0;
         clr_rsp_ff   <= 1'b0;
         lp_ff        <= PW'(PROBE_FLOOR);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         clr_rsp_ff   <= clr_rsp_in;
         lp_ff        <= lp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      home_ff  <= home_in;
      step_ff  <= step_in;
      probe_ff <= probe_in;
      cmd_ff   <= cmd_in;
      hash_ff  <= hash_in;
      cur_ff   <= cur_in;
      ck_ff    <= ck_in;
      sts_ff   <= sts_in;
      slot_ff  <= slot_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

### sv/robin_hood_hash_table_top.sv
// Robin Hood hash table with open addressing over CAPACITY slots.
// Input words (req_) carry a command: insert, find or clear. Every word
// gives exactly one result word (rsp_) with status, slot, longest probe
// and a resize hint. A word is taken when valid is high and stall is low.
// Configuration (csr_) sets table size and key length; write it only
// while no command is in flight.
// The home slot comes from the remainder unit (4 bits a cycle).
// A find then reads and compares one probed slot at a time. An insert first
// scans for an empty slot, slot by slot, then walks, getting the home of each
// occupied slot's resident via the remainder unit, and writes the final slot.
// A clear, and the pass after reset, writes one slot a cycle over all CAPACITY
// slots; req_stall stays high during it. One command is worked at a time;
// a new word is taken while the previous result still waits under
// rsp_stall, and the block then holds its next result until taken.
`timescale 1ns / 1ps
`default_nettype none

module robin_hood_hash_table_top #(
   parameter int CAPACITY      = 1024,
   parameter int MAX_KEY_BYTES = 32,
   parameter int PROBE_FLOOR   = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire rhh_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output rhh_pkg::rsp_type                       rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [rhh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rhh_pkg::CSR_W-1:0]         csr_wdata
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int SZ_W  = $clog2(CAPACITY + 1);
   localparam int KW    = MAX_KEY_BYTES * 8;

   logic [rhh_pkg::TS_W-1:0]     table_size_ff;
   logic [rhh_pkg::KB_W-1:0]     key_bytes_ff;
   rhh_pkg::mem_ctl_type         mem_ctl;
   logic [IDX_W-1:0]             mem_addr;
   logic [rhh_pkg::ENTRY_W-1:0]  mem_wr_entry;
   logic [KW-1:0]                mem_wr_key;
   logic [rhh_pkg::ENTRY_W-1:0]  mem_rd_entry;
   logic [KW-1:0]                mem_rd_key;
   logic                         div_start;
   logic [rhh_pkg::HASH_W-1:0]   div_dividend;
   logic [SZ_W-1:0]              div_divisor;
   logic                         div_done;
   logic [SZ_W-1:0]              div_rem;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_size_ff <= rhh_pkg::TS_W'(1021);
         key_bytes_ff  <= rhh_pkg::KB_W'(32);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            rhh_pkg::CSR_TABLE_SIZE: table_size_ff <= csr_wdata[rhh_pkg::TS_W-1:0];
            rhh_pkg::CSR_KEY_BYTES:  key_bytes_ff  <= csr_wdata[rhh_pkg::KB_W-1:0];
            default: ;
         endcase
      end
   end

   rhh_ctrl #(
      .CAPACITY      (CAPACITY),
      .MAX_KEY_BYTES (MAX_KEY_BYTES),
      .PROBE_FLOOR   (PROBE_FLOOR)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .table_size   (table_size_ff),
      .key_bytes    (key_bytes_ff),
      .mem_ctl      (mem_ctl),
      .mem_addr     (mem_addr),
      .mem_wr_entry (mem_wr_entry),
      .mem_wr_key   (mem_wr_key),
      .mem_rd_entry (mem_rd_entry),
      .mem_rd_key   (mem_rd_key),
      .div_start    (div_start),
      .div_dividend (div_dividend),
      .div_divisor  (div_divisor),
      .div_done     (div_done),
      .div_rem      (div_rem)
   );

   rhh_store #(
      .CAPACITY (CAPACITY),
      .KW       (KW)
   ) u_store (
      .clock    (clock),
      .ctl      (mem_ctl),
      .addr     (mem_addr),
      .wr_entry (mem_wr_entry),
      .wr_key   (mem_wr_key),
      .rd_entry (mem_rd_entry),
      .rd_key   (mem_rd_key)
   );

   rhh_mod #(
      .SZ_W (SZ_W)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS      = 1024;
   localparam int KEY_MAX    = 32;
   localparam int FLOOR      = 24;
   localparam int WATCH_MAX  = 60000;
   localparam int LONG_HOLD  = 400;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   rhh_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   rhh_pkg::rsp_type              rsp_data;
   logic                          csr_wr_en = 1'b0;
   logic [rhh_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [rhh_pkg::CSR_W-1:0]     csr_wdata = '0;

   robin_hood_hash_table_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // mirror of the table contents and settings
   logic [31:0] slot_hash [SLOTS];
   logic [31:0] slot_tag [SLOTS];
   logic [63:0] slot_key [SLOTS][4];
   int unsigned probe_max;
   int unsigned size_reg;
   int unsigned keylen_reg;

   rhh_pkg::rsp_type expected_rsps[$];
   int      fail_count = 0;
   int      idle_cycles = 0;
   bit      calm = 1'b0;
   bit      hold_request = 1'b0;

   logic [31:0]  known_hash[$];
   logic [255:0] known_key[$];

   function automatic logic [63:0] key_mask(int unsigned kb, int unsigned w);
      int unsigned lo;
      lo = w * 8;
      if (kb <= lo) return '0;
      if (kb - lo >= 8) return '1;
      return (64'd1 << (8 * (kb - lo))) - 64'd1;
   endfunction

   function automatic rhh_pkg::rsp_type predict_table(rhh_pkg::req_type w);
      int unsigned sz, kb, idx, probe, d, rh, home, last;
      logic [31:0] ch, ct, th, tt;
      logic [63:0] ck[4], tk[4], kin[4];
      bit          has_empty, eq;
      rhh_pkg::rsp_type r;
      sz = size_reg < 2 ? 2 : (size_reg > SLOTS ? SLOTS : size_reg);
      kb = keylen_reg < 1 ? 1 : (keylen_reg > KEY_MAX ? KEY_MAX : keylen_reg);
      kin = '{w.key_word0, w.key_word1, w.key_word2, w.key_word3};
      r = '0;
      case (w.command) inside
         rhh_pkg::CMD_INSERT, rhh_pkg::CMD_FIND: begin
            if (w.hash_value == 0) begin
               r.status = rhh_pkg::STS_ZERO_HASH;
            end else if (w.command == rhh_pkg::CMD_INSERT) begin
               has_empty = 1'b0;
               for (int i = 0; i < sz; i++) if (slot_hash[i] == 0) has_empty = 1'b1;
               if (!has_empty) begin
                  r.status = rhh_pkg::STS_FULL;
               end else begin
                  r.status = rhh_pkg::STS_INSERTED;
                  ch = w.hash_value;
                  ct = w.entry_tag;
                  for (int k = 0; k < 4; k++) ck[k] = kin[k] & key_mask(kb, k);
                  probe = 0;
                  idx = w.hash_value % sz;
                  for (int step = 0; step < sz; step++) begin
                     rh = slot_hash[idx];
                     if (rh == 0) begin
                        slot_hash[idx] = ch;
                        slot_tag[idx] = ct;
                        slot_key[idx] = ck;
                        if (probe > probe_max) probe_max = probe;
                        break;
                     end
                     home = rh % sz;
                     d = idx >= home ? idx - home : idx + sz - home;
                     // trade places with a resident nearer its home
                     if (d < probe) begin
                        th = slot_hash[idx];
                        tt = slot_tag[idx];
                        tk = slot_key[idx];
                        slot_hash[idx] = ch;
                        slot_tag[idx] = ct;
                        slot_key[idx] = ck;
                        if (probe > probe_max) probe_max = probe;
                        ch = th;
                        ct = tt;
                        ck = tk;
                        probe = d;
                     end
                     probe++;
                     idx = idx + 1 >= sz ? 0 : idx + 1;
                  end
               end
            end else begin
               r.status = rhh_pkg::STS_NOT_FOUND;
               last = probe_max < sz - 1 ? probe_max : sz - 1;
               idx = w.hash_value % sz;
               for (int i = 0; i <= last; i++) begin
                  if (slot_hash[idx] == w.hash_value) begin
                     eq = 1'b1;
                     for (int k = 0; k < 4; k++)
                        if ((slot_key[idx][k] & key_mask(kb, k)) != (kin[k] & key_mask(kb, k)))
                           eq = 1'b0;
                     if (eq) begin
                        r.status = rhh_pkg::STS_FOUND;
                        r.slot_index = rhh_pkg::SLOT_W'(idx);
                        break;
                     end
                  end
                  idx = idx + 1 >= sz ? 0 : idx + 1;
               end
            end
         end
         rhh_pkg::CMD_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
               slot_hash[i] = '0;
               slot_tag[i] = '0;
            end
            r.status = rhh_pkg::STS_INSERTED;
         end
         default: r.status = rhh_pkg::STS_NOT_FOUND;
      endcase
      r.longest_probe_out = rhh_pkg::LP_OUT_W'(probe_max);
      r.resize_wanted = probe_max > FLOOR;
      return r;
   endfunction

   // offer one word, hold it until taken, then log its expected result
   task automatic send_word(rhh_pkg::req_type w, bit fixed, rhh_pkg::rsp_type fixed_rsp);
      rhh_pkg::rsp_type p;
      @(negedge clock);
      while (!calm && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (req_stall);
      p = predict_table(w);
      expected_rsps.push_back(fixed ? fixed_rsp : p);
      if (w.command == rhh_pkg::CMD_CLEAR) begin
         known_hash.delete();
         known_key.delete();
      end
      if (w.command == rhh_pkg::CMD_INSERT && w.hash_value != 0) begin
         known_hash.push_back(w.hash_value);
         known_key.push_back({w.key_word3, w.key_word2, w.key_word1, w.key_word0});
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(rhh_pkg::csr_index_type idx, int unsigned value);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= rhh_pkg::CSR_W'(value);
      if (idx == rhh_pkg::CSR_TABLE_SIZE) size_reg = value & 32'h7FF;
      else keylen_reg = value & 32'h3F;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // result side: random stall, plus one long hold counted here
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && $urandom_range(99) < 23;
         end
      end
   end

   // compare each taken result with the oldest expectation
   always @(posedge clock) begin
      rhh_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.slot_index !== e.slot_index) begin
               $error("slot_index: expected %0d, got %0d", e.slot_index, rsp_data.slot_index);
               fail_count++;
            end
            if (rsp_data.longest_probe_out !== e.longest_probe_out) begin
               $error("longest_probe_out: expected %0d, got %0d",
                      e.longest_probe_out, rsp_data.longest_probe_out);
               fail_count++;
            end
            if (rsp_data.resize_wanted !== e.resize_wanted) begin
               $error("resize_wanted: expected %0d, got %0d",
                      e.resize_wanted, rsp_data.resize_wanted);
               fail_count++;
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_MAX) begin
         $display("Verification failed");
         $finish;
      end
   end

   typedef struct {
      rhh_pkg::req_type w;
      bit               fixed;
      rhh_pkg::rsp_type r;
   } dir_row_type;

   dir_row_type dir_rows[$];

   task automatic add_row(logic [1:0] cmd, logic [31:0] h, logic [31:0] t, logic [63:0] k,
                          bit fixed, rhh_pkg::status_type s);
      dir_row_type row;
      row.w = '{cmd, h, t, k, k, k, k};
      row.fixed = fixed;
      row.r = '0;
      row.r.status = s;
      row.r.longest_probe_out = rhh_pkg::LP_OUT_W'(FLOOR);
      dir_rows.push_back(row);
   endtask

   typedef struct {
      int unsigned size;
      int unsigned klen;
      int unsigned span;
      int unsigned count;
      bit          wipe;
      bit          quiet;
      bit          hold;
   } phase_type;

   initial begin
      phase_type        phases[8];
      rhh_pkg::req_type w;
      rhh_pkg::rsp_type none;
      int unsigned sz, kb, pick, n;
      logic [255:0] k;
      logic [31:0]  h;

      for (int i = 0; i < SLOTS; i++) begin
         slot_hash[i] = '0;
         slot_tag[i] = '0;
         slot_key[i] = '{default: '0};
      end
      probe_max = FLOOR;
      size_reg = 1021;
      keylen_reg = 32;
      none = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed rows at reset settings
      add_row(rhh_pkg::CMD_FIND,   32'd5,        '0, '0, 1, rhh_pkg::STS_NOT_FOUND);
      add_row(rhh_pkg::CMD_INSERT, 32'd0,        '1, '1, 1, rhh_pkg::STS_ZERO_HASH);
      add_row(rhh_pkg::CMD_FIND,   32'd0,        '0, '1, 1, rhh_pkg::STS_ZERO_HASH);
      add_row(CMD_UNUSED,          32'd7,        '1, '1, 1, rhh_pkg::STS_NOT_FOUND);
      add_row(rhh_pkg::CMD_INSERT, 32'hFFFFFFFF, '1, '1, 1, rhh_pkg::STS_INSERTED);
      add_row(rhh_pkg::CMD_FIND,   32'hFFFFFFFF, '0, '1, 0, rhh_pkg::STS_FOUND);
      add_row(rhh_pkg::CMD_INSERT, 32'hFFFFFFFF, '0, '1, 0, rhh_pkg::STS_INSERTED);
      add_row(rhh_pkg::CMD_INSERT, 32'd1,        '0, '0, 0, rhh_pkg::STS_INSERTED);
      add_row(rhh_pkg::CMD_FIND,   32'd1,        '1, '0, 0, rhh_pkg::STS_FOUND);
      add_row(rhh_pkg::CMD_FIND,   32'd1,        '0, 64'h8000_0000_0000_0000, 0,
              rhh_pkg::STS_NOT_FOUND);
      add_row(rhh_pkg::CMD_INSERT, 32'd1022,     '0, 64'h5A5A, 0, rhh_pkg::STS_INSERTED);
      add_row(rhh_pkg::CMD_FIND,   32'd1022,     '0, 64'h5A5A, 0, rhh_pkg::STS_FOUND);
      add_row(rhh_pkg::CMD_FIND,   32'd2043,     '0, '0, 0, rhh_pkg::STS_NOT_FOUND);
      add_row(rhh_pkg::CMD_CLEAR,  32'd0,        '0, '0, 1, rhh_pkg::STS_INSERTED);
      add_row(rhh_pkg::CMD_FIND,   32'hFFFFFFFF, '0, '1, 1, rhh_pkg::STS_NOT_FOUND);
      foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].r);

      // size, key length, home spread, items, clear first, calm, long hold
      phases[0] = '{7,    8,  7,    60,  1, 0, 0};
      phases[1] = '{2,    1,  2,    40,  1, 0, 0};
      phases[2] = '{0,    0,  2,    20,  1, 0, 0};
      phases[3] = '{61,   16, 3,    120, 1, 0, 1};
      phases[4] = '{1024, 32, 1024, 60,  1, 1, 0};
      phases[5] = '{2047, 63, 8,    60,  0, 0, 0};
      phases[6] = '{13,   5,  13,   80,  0, 0, 0};
      phases[7] = '{31,   20, 4,    100, 1, 0, 0};

      foreach (phases[p]) begin
         write_reg(rhh_pkg::CSR_TABLE_SIZE, phases[p].size);
         write_reg(rhh_pkg::CSR_KEY_BYTES, phases[p].klen);
         sz = size_reg < 2 ? 2 : (size_reg > SLOTS ? SLOTS : size_reg);
         kb = keylen_reg < 1 ? 1 : (keylen_reg > KEY_MAX ? KEY_MAX : keylen_reg);
         calm = phases[p].quiet;
         if (phases[p].wipe) begin
            w = '0;
            w.command = rhh_pkg::CMD_CLEAR;
            send_word(w, 0, none);
         end
         n = 0;
         while (n < phases[p].count) begin
            if (phases[p].hold && n == 20) hold_request = 1'b1;
            w.entry_tag = $urandom;
            k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom};
            h = $urandom;
            if ($urandom_range(3) != 0)
               h = h - (h % sz) + $urandom_range(phases[p].span - 1);
            pick = $urandom_range(99);
            if (pick < 48) begin
               w.command = rhh_pkg::CMD_INSERT;
            end else if (pick < 90) begin
               w.command = rhh_pkg::CMD_FIND;
               // mostly look up a stored key, sometimes with bytes past the length flipped
               if (known_hash.size() > 0 && $urandom_range(9) < 7) begin
                  pick = $urandom_range(known_hash.size() - 1);
                  h = known_hash[pick];
                  if ($urandom_range(3) == 0) begin
                     for (int q = 0; q < 4; q++)
                        k[q*64 +: 64] = known_key[pick][q*64 +: 64] ^
                                        (k[q*64 +: 64] & ~key_mask(kb, q));
                  end else if ($urandom_range(4) != 0) begin
                     k = known_key[pick];
                  end
               end
            end else if (pick < 93) begin
               w.command = rhh_pkg::CMD_CLEAR;
            end else if (pick < 97) begin
               w.command = $urandom_range(1) ? rhh_pkg::CMD_INSERT : rhh_pkg::CMD_FIND;
               h = '0;
            end else begin
               w.command = CMD_UNUSED;
            end
            w.hash_value = h;
            {w.key_word3, w.key_word2, w.key_word1, w.key_word0} = k;
            send_word(w, 0, none);
            n++;
         end
         // let everything come back before the next setting
         drain();
         calm = 1'b0;
      end

      drain();
      repeat (50) @(posedge clock);
      if (fail_count == 0 && expected_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
